@@ hw/rtl/aidn_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the adaptive interval distance normaliser
// used by aidn_sdiv and adaptive_interval_distance_normalizer, no dependencies

package aidn_pkg;

  // field and datapath widths
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned TIME_W    = 40;
  localparam int unsigned WEIGHT_W  = 20;
  localparam int unsigned NUM_W     = 2 * DATA_W;
  localparam int unsigned CFG_IDX_W = 2;

  // digit-serial multiplier geometry
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned DIGITS  = WEIGHT_W / DIGIT_W;
  localparam int unsigned MCNT_W  = $clog2(DIGITS);
  localparam int unsigned MCAND_W = DATA_W + WEIGHT_W;
  localparam int unsigned ACC_W   = MCAND_W + 1;

  // bit-serial divider iteration counter width
  localparam int unsigned DCNT_W = $clog2(DATA_W);

  // fixed-point scale and clip factor
  localparam logic [WEIGHT_W-1:0] SCALE_W     = 20'd1000000;
  localparam logic [DATA_W-1:0]   SCALE       = 64'd1000000;
  localparam logic [DATA_W-1:0]   CLIP_FACTOR = 64'd10;

  // register reset values
  localparam logic [WEIGHT_W-1:0] RST_FAST = 20'd10000;
  localparam logic [WEIGHT_W-1:0] RST_SLOW = 20'd200;
  localparam logic [WEIGHT_W-1:0] RST_MEAN = 20'd100;
  localparam logic [DATA_W-1:0]   RST_TOP  = 64'd2000000;
  localparam logic [DATA_W-1:0]   RST_BOT  = 64'd1000000;
  localparam logic [DATA_W-1:0]   RST_MD   = 64'd1000000;
  localparam logic [DATA_W-1:0]   RST_LOW  = 64'd1000000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST = 2'd0,
    CFG_SLOW = 2'd1,
    CFG_MEAN = 2'd2
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DBOT_GO,
    ST_DBOT_WAIT,
    ST_CLIP1,
    ST_BL_LOAD,
    ST_BL_MUL_A,
    ST_BL_MUL_B,
    ST_BL_DIV_GO,
    ST_BL_DIV_WAIT,
    ST_CHECK,
    ST_DIST_MUL,
    ST_DIST_GO,
    ST_DIST_WAIT,
    ST_DLOW_GO,
    ST_DLOW_WAIT,
    ST_CLIP2,
    ST_OUT
  } state_e;

  // which tracker the shared moving average is updating
  typedef enum logic [1:0] {
    BL_TOP,
    BL_BOT,
    BL_LOW,
    BL_MEAN
  } bsel_e;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ hw/rtl/aidn_sdiv.sv @@
`timescale 1ns / 1ps
// bit-serial restoring divider, 128-bit numerator by 64-bit divisor, one quotient bit a cycle
// quotient saturates to all ones when it would not fit in 64 bits; uses aidn_pkg

module aidn_sdiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aidn_pkg::div_req_t req_i,
  output aidn_pkg::div_rsp_t rsp_o
);
  import aidn_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] lo_q, lo_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] den_q, den_d;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              take;
  logic              sat;

  // one restoring step: shift in the next numerator bit and try the divisor
  assign trial = {rem_q, lo_q[DATA_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign take  = trial >= {1'b0, den_q};
  assign sat   = req_i.num[NUM_W-1:DATA_W] >= req_i.den;

  // control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      cnt_d = '1;
      if (sat) begin
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end
  end

  // datapath
  always_comb begin
    rem_d = rem_q;
    lo_d  = lo_q;
    quo_d = quo_q;
    den_d = den_q;
    if (busy_q) begin
      rem_d = take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      lo_d  = {lo_q[DATA_W-2:0], 1'b0};
      quo_d = {quo_q[DATA_W-2:0], take};
    end else if (req_i.start) begin
      rem_d = req_i.num[NUM_W-1:DATA_W];
      lo_d  = req_i.num[DATA_W-1:0];
      den_d = req_i.den;
      quo_d = sat ? '1 : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

@@ hw/rtl/adaptive_interval_distance_normalizer.sv @@
`timescale 1ns / 1ps
// Adaptive interval distance normaliser. One item (two 40-bit timestamps) is taken at a time
// and gives one result (distance, threshold). An item is done soonest when the spans are
// degenerate, later when the difference is at or below the lower span and last otherwise.
// The time is set by the single bit-serial divider, which runs a start, 64 steps and a done
// per quotient and is used up to seven times per item (two divisions by ten, four
// moving-average divisions by one million and the distance division), plus the load and the
// two 4-bit-digit multiplier passes of each moving average and the distance product; a
// saturating division skips the steps. The output register lets the next item start while a
// result waits. Configuration writes are always ready and must only be issued while the block
// is idle. Uses aidn_pkg and aidn_sdiv.

module adaptive_interval_distance_normalizer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [2*aidn_pkg::TIME_W-1:0]      s_axis_tdata,   // time_a [39:0], time_b [79:40]
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [2*aidn_pkg::DATA_W-1:0]      m_axis_tdata,   // distance [63:0], threshold [127:64]
  // configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [aidn_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [aidn_pkg::WEIGHT_W-1:0]      cfg_data_i
);
  import aidn_pkg::*;

  // times ten, saturating at 64 bits
  function automatic logic [DATA_W-1:0] times10(input logic [DATA_W-1:0] x);
    logic [DATA_W+3:0] t;
    t = {1'b0, x, 3'b000} + {3'b000, x, 1'b0};
    return (t[DATA_W+3:DATA_W] != '0) ? '1 : t[DATA_W-1:0];
  endfunction

  // clip with the upper bound winning
  function automatic logic [DATA_W-1:0] clip(input logic [DATA_W-1:0] x,
                                             input logic [DATA_W-1:0] lo,
                                             input logic [DATA_W-1:0] hi);
    logic [DATA_W-1:0] y;
    y = (x < lo) ? lo : x;
    return (y > hi) ? hi : y;
  endfunction

  state_e state_q, state_d;
  bsel_e  bsel_q;
  logic [MCNT_W-1:0] mcnt_q;

  logic [WEIGHT_W-1:0] fast_q, slow_q, mw_q;
  logic [DATA_W-1:0]   top_q, bot_q, mean_q, low_q;

  logic [DATA_W-1:0]   diff_q, lo_q, dc_q, dist_q;
  logic [MCAND_W-1:0]  mcand_q;
  logic [WEIGHT_W-1:0] mplier_q, bw_q;
  logic [ACC_W-1:0]    acc_q;

  logic              m_valid_q;
  logic [DATA_W-1:0] m_dist_q, m_thr_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                  in_xfer, out_free, mul_last;
  logic [TIME_W-1:0]     time_a, time_b;
  logic [DATA_W-1:0]     clip1, clip2;
  logic [DATA_W-1:0]     bl_val, bl_old;
  logic                  bl_lt;
  logic [WEIGHT_W-1:0]   bl_w_raw, bl_w;
  logic [DIGIT_W-1:0]    digit;
  logic [MCAND_W+DIGIT_W-1:0] pp;
  logic [ACC_W-1:0]      acc_sum;
  logic                  span_ok, diff_above;

  aidn_sdiv u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign time_a   = s_axis_tdata[TIME_W-1:0];
  assign time_b   = s_axis_tdata[2*TIME_W-1:TIME_W];
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign mul_last = mcnt_q == MCNT_W'(DIGITS - 1);

  assign clip1 = clip(diff_q, lo_q, times10(top_q));
  assign clip2 = clip(dist_q, lo_q, times10(mean_q));

  assign span_ok    = top_q > bot_q;
  assign diff_above = diff_q > bot_q;

  // operands of the shared moving average
  always_comb begin
    bl_val = (bsel_q == BL_TOP || bsel_q == BL_BOT) ? diff_q : dc_q;
    unique case (bsel_q)
      BL_TOP:  bl_old = top_q;
      BL_BOT:  bl_old = bot_q;
      BL_LOW:  bl_old = low_q;
      BL_MEAN: bl_old = mean_q;
      default: bl_old = top_q;
    endcase
    bl_lt = bl_val < bl_old;
    unique case (bsel_q)
      BL_TOP:  bl_w_raw = bl_lt ? slow_q : fast_q;
      BL_BOT:  bl_w_raw = bl_lt ? fast_q : slow_q;
      BL_LOW:  bl_w_raw = bl_lt ? fast_q : slow_q;
      BL_MEAN: bl_w_raw = mw_q;
      default: bl_w_raw = mw_q;
    endcase
    bl_w = (bl_w_raw > SCALE_W) ? SCALE_W : bl_w_raw;
  end

  // one 4-bit digit of the multiplier per cycle
  assign digit   = mplier_q[DIGIT_W-1:0];
  assign pp      = {{DIGIT_W{1'b0}}, mcand_q} * {{MCAND_W{1'b0}}, digit};
  assign acc_sum = acc_q + pp[ACC_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:        if (in_xfer) state_d = ST_DBOT_GO;
      ST_DBOT_GO:     state_d = ST_DBOT_WAIT;
      ST_DBOT_WAIT:   if (div_rsp.done) state_d = ST_CLIP1;
      ST_CLIP1:       state_d = ST_BL_LOAD;
      ST_BL_LOAD:     state_d = ST_BL_MUL_A;
      ST_BL_MUL_A:    if (mul_last) state_d = ST_BL_MUL_B;
      ST_BL_MUL_B:    if (mul_last) state_d = ST_BL_DIV_GO;
      ST_BL_DIV_GO:   state_d = ST_BL_DIV_WAIT;
      ST_BL_DIV_WAIT: begin
        if (div_rsp.done) begin
          unique case (bsel_q)
            BL_TOP:  state_d = ST_BL_LOAD;
            BL_BOT:  state_d = ST_CHECK;
            BL_LOW:  state_d = ST_BL_LOAD;
            BL_MEAN: state_d = ST_OUT;
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_CHECK: begin
        if (!span_ok) begin
          state_d = ST_OUT;
        end else if (diff_above) begin
          state_d = ST_DIST_MUL;
        end else begin
          state_d = ST_DLOW_GO;
        end
      end
      ST_DIST_MUL:    if (mul_last) state_d = ST_DIST_GO;
      ST_DIST_GO:     state_d = ST_DIST_WAIT;
      ST_DIST_WAIT:   if (div_rsp.done) state_d = ST_DLOW_GO;
      ST_DLOW_GO:     state_d = ST_DLOW_WAIT;
      ST_DLOW_WAIT:   if (div_rsp.done) state_d = ST_CLIP2;
      ST_CLIP2:       state_d = ST_BL_LOAD;
      ST_OUT:         if (out_free) state_d = ST_IDLE;
      default:        state_d = ST_IDLE;
    endcase
  end

  // state outputs: input ready and divider requests
  always_comb begin
    s_axis_tready = 1'b0;
    div_req       = '0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_DBOT_GO: begin
        div_req.start = 1'b1;
        div_req.num   = NUM_W'(bot_q);
        div_req.den   = CLIP_FACTOR;
      end
      ST_BL_DIV_GO: begin
        div_req.start = 1'b1;
        div_req.num   = NUM_W'(acc_q);
        div_req.den   = SCALE;
      end
      ST_DIST_GO: begin
        div_req.start = 1'b1;
        div_req.num   = NUM_W'(acc_q);
        div_req.den   = top_q - bot_q;
      end
      ST_DLOW_GO: begin
        div_req.start = 1'b1;
        div_req.num   = NUM_W'(low_q);
        div_req.den   = CLIP_FACTOR;
      end
      default: ;
    endcase
  end

  // sequencer control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bsel_q  <= BL_TOP;
      mcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_BL_LOAD || state_q == ST_CHECK) begin
        mcnt_q <= '0;
      end else if (state_q == ST_BL_MUL_A || state_q == ST_BL_MUL_B ||
                   state_q == ST_DIST_MUL) begin
        mcnt_q <= mul_last ? '0 : mcnt_q + 1'b1;
      end
      if (state_q == ST_CLIP1) begin
        bsel_q <= BL_TOP;
      end else if (state_q == ST_CLIP2) begin
        bsel_q <= BL_LOW;
      end else if (state_q == ST_BL_DIV_WAIT && div_rsp.done) begin
        if (bsel_q == BL_TOP) begin
          bsel_q <= BL_BOT;
        end else if (bsel_q == BL_LOW) begin
          bsel_q <= BL_MEAN;
        end
      end
    end
  end

  // configuration registers, a write is a transfer on the config channel
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= RST_FAST;
      slow_q <= RST_SLOW;
      mw_q   <= RST_MEAN;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FAST: fast_q <= cfg_data_i;
        CFG_SLOW: slow_q <= cfg_data_i;
        CFG_MEAN: mw_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // trackers, written when a moving-average division finishes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= RST_TOP;
      bot_q  <= RST_BOT;
      mean_q <= RST_MD;
      low_q  <= RST_LOW;
    end else if (state_q == ST_BL_DIV_WAIT && div_rsp.done) begin
      unique case (bsel_q)
        BL_TOP:  top_q  <= div_rsp.quo;
        BL_BOT:  bot_q  <= div_rsp.quo;
        BL_LOW:  low_q  <= div_rsp.quo;
        BL_MEAN: mean_q <= div_rsp.quo;
        default: ;
      endcase
    end
  end

  // working registers of the item in flight
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          diff_q <= DATA_W'((time_a > time_b) ? time_a - time_b : time_b - time_a);
        end
      end
      ST_DBOT_WAIT: if (div_rsp.done) lo_q <= div_rsp.quo;
      ST_CLIP1:     diff_q <= clip1;
      ST_BL_LOAD: begin
        mcand_q  <= MCAND_W'(bl_val);
        mplier_q <= bl_w;
        bw_q     <= bl_w;
        acc_q    <= '0;
      end
      ST_BL_MUL_A: begin
        acc_q <= acc_sum;
        if (mul_last) begin
          // second pass: complementary weight times the old value
          mcand_q  <= MCAND_W'(bl_old);
          mplier_q <= SCALE_W - bw_q;
        end else begin
          mcand_q  <= {mcand_q[MCAND_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          mplier_q <= {{DIGIT_W{1'b0}}, mplier_q[WEIGHT_W-1:DIGIT_W]};
        end
      end
      ST_BL_MUL_B, ST_DIST_MUL: begin
        acc_q    <= acc_sum;
        mcand_q  <= {mcand_q[MCAND_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        mplier_q <= {{DIGIT_W{1'b0}}, mplier_q[WEIGHT_W-1:DIGIT_W]};
      end
      ST_CHECK: begin
        dist_q   <= '0;
        mcand_q  <= MCAND_W'(diff_q - bot_q);
        mplier_q <= SCALE_W;
        acc_q    <= '0;
      end
      ST_DIST_WAIT: if (div_rsp.done) dist_q <= div_rsp.quo;
      ST_DLOW_WAIT: if (div_rsp.done) lo_q <= div_rsp.quo;
      ST_CLIP2:     dc_q <= clip2;
      default: ;
    endcase
  end

  // output register, a new result loads once the previous transfer is done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      m_dist_q <= dist_q;
      m_thr_q  <= low_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_thr_q, m_dist_q};

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// self-checking bench for adaptive_interval_distance_normalizer: random timestamp pairs
// under several weight settings, results checked against an in-bench tracker model
// depends on aidn_pkg and the normaliser rtl

module testbench;
  import aidn_pkg::*;

  typedef logic [TIME_W-1:0]   stamp_t;
  typedef logic [DATA_W-1:0]   word_t;
  typedef logic [NUM_W-1:0]    wide_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

  // input transfer, time_a in the low bits
  typedef struct packed {
    stamp_t time_b;
    stamp_t time_a;
  } interval_t;

  // result transfer, distance in the low bits
  typedef struct packed {
    word_t threshold;
    word_t distance;
  } norm_result_t;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 4000;
  localparam int unsigned DRAIN_CYCLES = 600;
  localparam int unsigned NUM_PHASES   = 11;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [2*TIME_W-1:0]    s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [2*DATA_W-1:0]    m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [WEIGHT_W-1:0]    cfg_data_i    = '0;

  adaptive_interval_distance_normalizer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // tracker model state and weights
  word_t   upper_span, lower_span, dist_mean, dist_floor;
  weight_t w_fast, w_slow, w_mean;

  interval_t    pending_q[$];
  norm_result_t expected_q[$];

  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt  = 0;
  int unsigned fed_cnt      = 0;
  int unsigned err_cnt      = 0;
  int unsigned degen_cnt    = 0;
  int unsigned crossed_cnt  = 0;
  int unsigned cycle_cnt    = 0;
  logic        no_idle      = 1'b0;

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d of %0d results seen", cycle_cnt, checked_cnt,
             fed_cnt);
    $display("FAIL");
    $finish;
  end

  // quotient saturated to 64 bits
  function automatic word_t sat_quot(wide_t num, word_t den);
    wide_t q;
    if (den == '0) return '1;
    q = num / wide_t'(den);
    if (q[NUM_W-1:DATA_W] != '0) return '1;
    return q[DATA_W-1:0];
  endfunction

  // per-million moving average, weights above one million act as one million
  function automatic word_t weighted_avg(weight_t w, word_t val, word_t old);
    wide_t w_new, w_old, acc;
    w_new = wide_t'((w > SCALE_W) ? SCALE_W : w);
    w_old = wide_t'(SCALE) - w_new;
    acc   = w_new * wide_t'(val) + w_old * wide_t'(old);
    return sat_quot(acc, SCALE);
  endfunction

  function automatic word_t x10_sat(word_t x);
    wide_t p;
    p = wide_t'(x) * wide_t'(CLIP_FACTOR);
    return (p[NUM_W-1:DATA_W] != '0) ? '1 : p[DATA_W-1:0];
  endfunction

  // lower bound first, upper bound wins when they cross
  function automatic word_t bound(word_t x, word_t lo, word_t hi);
    if (lo > hi) crossed_cnt++;
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    return x;
  endfunction

  // one accepted pair of timestamps: update trackers, give the expected result
  function automatic norm_result_t predict_interval(interval_t it);
    word_t        d, norm_dist, dc;
    wide_t        num;
    norm_result_t r;
    d = word_t'((it.time_a > it.time_b) ? it.time_a - it.time_b : it.time_b - it.time_a);
    d = bound(d, lower_span / CLIP_FACTOR, x10_sat(upper_span));
    upper_span = weighted_avg((d < upper_span) ? w_slow : w_fast, d, upper_span);
    lower_span = weighted_avg((d < lower_span) ? w_fast : w_slow, d, lower_span);
    norm_dist = '0;
    if (upper_span > lower_span) begin
      if (d > lower_span) begin
        num       = wide_t'(d - lower_span);
        num       = num * wide_t'(SCALE);
        norm_dist = sat_quot(num, upper_span - lower_span);
      end
      dc         = bound(norm_dist, dist_floor / CLIP_FACTOR, x10_sat(dist_mean));
      dist_floor = weighted_avg((dc < dist_floor) ? w_fast : w_slow, dc, dist_floor);
      dist_mean  = weighted_avg(w_mean, dc, dist_mean);
    end else begin
      degen_cnt++;
    end
    r.distance  = norm_dist;
    r.threshold = dist_floor;
    return r;
  endfunction

  function automatic stamp_t rand_stamp();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[TIME_W-1:0];
  endfunction

  // mostly intervals of varied magnitude, some wide noise and equal stamps
  function automatic interval_t rand_interval();
    interval_t it;
    stamp_t    delta;
    int unsigned pick;
    pick      = $urandom_range(0, 19);
    it.time_a = rand_stamp();
    delta     = rand_stamp() >> $urandom_range(6, 39);
    if (pick < 2)
      it.time_b = rand_stamp();
    else if (pick == 2)
      it.time_b = it.time_a;
    else if (pick[0])
      it.time_b = it.time_a + delta;
    else
      it.time_b = it.time_a - delta;
    return it;
  endfunction

  function automatic weight_t rand_weight();
    case ($urandom_range(0, 3))
      0:       return weight_t'($urandom_range(0, 1000000));
      1:       return weight_t'($urandom_range(0, 20000));
      2:       return weight_t'($urandom_range(0, 1000));
      default: return weight_t'($urandom_range(1000000, 20'hFFFFF));
    endcase
  endfunction

  // input driver: one item per transfer, random gap before each
  int unsigned send_gap = 0;
  interval_t   cur_item;

  always @(posedge clk_i) begin
    logic nxt_valid;
    if (rst_ni) begin
      nxt_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(predict_interval(cur_item));
        accepted_cnt <= accepted_cnt + 1;
        nxt_valid = 1'b0;
        send_gap  = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (!nxt_valid && pending_q.size() != 0) begin
        if (send_gap != 0) begin
          send_gap--;
        end else begin
          cur_item     = pending_q.pop_front();
          s_axis_tdata <= cur_item;
          nxt_valid    = 1'b1;
        end
      end
      s_axis_tvalid <= nxt_valid;
    end
  end

  // result monitor and receiver stalls, with one long hold-off
  int unsigned recv_hold = 0;

  always @(posedge clk_i) begin
    logic         nxt_ready;
    norm_result_t got, want;
    if (rst_ni) begin
      nxt_ready = m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_q.size() == 0) begin
          $error("result transfer with no expectation pending");
          err_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (got.distance !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, got.distance);
            err_cnt++;
          end
          if (got.threshold !== want.threshold) begin
            $error("threshold: expected %0d, actual %0d", want.threshold, got.threshold);
            err_cnt++;
          end
        end
        checked_cnt <= checked_cnt + 1;
        nxt_ready = 1'b0;
        recv_hold = no_idle ? 0 : $urandom_range(0, 10);
        if (checked_cnt + 1 == HOLD_AT) recv_hold = HOLD_CYCLES;
      end
      if (!nxt_ready) begin
        if (recv_hold != 0) recv_hold--;
        else nxt_ready = 1'b1;
      end
      m_axis_tready <= nxt_ready;
    end
  end

  // register writes, model weights follow each accepted write
  task automatic program_weights(input weight_t f, input weight_t s, input weight_t m);
    logic [CFG_IDX_W-1:0] idx [4];
    weight_t              val [4];
    idx = '{CFG_FAST, CFG_SLOW, CFG_MEAN, CFG_SPARE};
    val = '{f, s, m, weight_t'($urandom_range(0, 20'hFFFFF))};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[i])
        CFG_FAST: w_fast = val[i];
        CFG_SLOW: w_slow = val[i];
        CFG_MEAN: w_mean = val[i];
        default:  ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic feed(input interval_t it);
    pending_q.push_back(it);
    fed_cnt++;
  endtask

  task automatic wait_drained();
    while (!(accepted_cnt == fed_cnt && checked_cnt == accepted_cnt && expected_q.size() == 0))
      @(posedge clk_i);
  endtask

  // stimulus sequence
  initial begin
    interval_t   it;
    weight_t     wf, ws, wm;
    int unsigned n_items;
    upper_span = RST_TOP;
    lower_span = RST_BOT;
    dist_mean  = RST_MD;
    dist_floor = RST_LOW;
    w_fast     = RST_FAST;
    w_slow     = RST_SLOW;
    w_mean     = RST_MEAN;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pairs under reset weights: stamp extremes and diffs around the spans
    feed('{time_b: '0, time_a: '0});
    feed('{time_b: '1, time_a: '1});
    feed('{time_b: '1, time_a: '0});
    feed('{time_b: '0, time_a: '1});
    feed('{time_b: 40'h0, time_a: 40'h1});
    feed('{time_b: 40'hAAAAAAAAAA, time_a: 40'h5555555555});
    feed('{time_b: 40'h5555555555, time_a: 40'hAAAAAAAAAA});
    feed('{time_b: 40'd99999, time_a: 40'd0});
    feed('{time_b: 40'd0, time_a: 40'd100000});
    feed('{time_b: 40'd5000000, time_a: 40'd6000000});
    feed('{time_b: 40'd1500000, time_a: 40'd0});
    feed('{time_b: 40'd0, time_a: 40'd2000000});
    feed('{time_b: 40'd20000000, time_a: 40'd0});
    feed('{time_b: 40'd0, time_a: 40'd30000000});
    feed('{time_b: 40'd123456789, time_a: 40'd123456789});
    feed('{time_b: 40'd1000, time_a: 40'd1001000});
    feed('{time_b: 40'hFFFFF00000, time_a: 40'hFFFFFFFFFF});
    feed('{time_b: 40'd7, time_a: 40'd3});
    wait_drained();

    // weight phases: degenerate, crossed bounds, over-range, frozen, random, defaults
    for (int p = 1; p <= NUM_PHASES; p++) begin
      n_items = 175;
      case (p)
        1: begin wf = SCALE_W; ws = SCALE_W; wm = SCALE_W; n_items = 150; end
        2: begin wf = '0;      ws = SCALE_W; wm = '0;      n_items = 150; end
        3: begin wf = '1;      ws = '0;      wm = '1;      n_items = 150; end
        4: begin wf = '0;      ws = '0;      wm = '0;      n_items = 100; end
        NUM_PHASES: begin wf = RST_FAST; ws = RST_SLOW; wm = RST_MEAN; n_items = 50; end
        default: begin wf = rand_weight(); ws = rand_weight(); wm = rand_weight(); end
      endcase
      no_idle = (p % 4 == 2);
      program_weights(wf, ws, wm);
      for (int i = 0; i < n_items; i++) begin
        it = rand_interval();
        feed(it);
      end
      wait_drained();
    end

    // quiet period to catch stray results
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (expected_q.size() != 0) begin
      void'(expected_q.pop_front());
      $error("expected result never arrived");
      err_cnt++;
    end

    $display("%0d timestamp pairs over %0d weight settings, %0d results checked",
             fed_cnt, NUM_PHASES + 1, checked_cnt);
    $display("degenerate spans on %0d items, crossed clip bounds %0d times",
             degen_cnt, crossed_cnt);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
